// ===== rtl/sil_pkg.sv =====
// ----------------------------------------------------------------------------
// sil_pkg
// Shared types and constants for the serial image loader framer: register
// indexes, reset values, stream widths and the structs between the top level
// and the frame core.
// ----------------------------------------------------------------------------
package sil_pkg;

  // Default width of the payload length and index
  localparam int LengthWidthDefault = 16;

  // Configuration register indexes
  localparam int CfgIndexWidth = 2;
  typedef enum logic [CfgIndexWidth-1:0] {
    REG_LOAD_BASE  = 2'd0,
    REG_MAX_LENGTH = 2'd1,
    REG_SYNC_VALUE = 2'd2
  } sil_reg_t;

  localparam int CfgDataWidth = 32;

  // Register reset values
  localparam logic [31:0] LoadBaseReset  = 32'h0000_1000;
  localparam logic [15:0] MaxLengthReset = 16'h3000;
  localparam logic [7:0]  SyncValueReset = 8'hA5;

  // Output stream: tdata holds write_address, write_data, length_error,
  // load_done from bit 0 up, zero filled to whole bytes
  localparam int OutDataWidth = 48;

  typedef struct packed {
    logic [31:0] load_base;
    logic [15:0] max_length;
    logic [7:0]  sync_value;
  } sil_cfg_t;

  typedef struct packed {
    logic        write_enable;
    logic [31:0] write_address;
    logic [7:0]  write_data;
    logic        length_error;
    logic        load_done;
  } sil_result_t;

endpackage

// ===== rtl/sil_core.sv =====
// ----------------------------------------------------------------------------
// sil_core
// Frame state machine: hunts for the sync byte, gathers the 4-byte
// little-endian length, checks it and numbers the payload bytes. The result
// for the byte presented on rx_byte is combinational; state advances when
// take is high.
// ----------------------------------------------------------------------------
module sil_core #(
  parameter int LENGTH_WIDTH = sil_pkg::LengthWidthDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [7:0]           rx_byte,
  input  sil_pkg::sil_cfg_t    cfg,
  output sil_pkg::sil_result_t result
);
  import sil_pkg::*;

  localparam logic [31:0] IndexLimit = 32'((64'd1 << LENGTH_WIDTH) - 64'd1);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_DONE,
    PH_ERROR
  } phase_t;

  phase_t                  phase, phase_next;
  logic [1:0]              length_byte_index, length_byte_index_next;
  logic [23:0]             length_low, length_low_next;
  logic [LENGTH_WIDTH-1:0] length, length_next;
  logic [LENGTH_WIDTH-1:0] payload_index, payload_index_next;

  logic [31:0]             length_full;
  logic [LENGTH_WIDTH:0]   index_plus_one;

  assign length_full    = {rx_byte, length_low};
  assign index_plus_one = {1'b0, payload_index} + {{LENGTH_WIDTH{1'b0}}, 1'b1};

  // Decode the byte against the current phase
  always_comb begin
    phase_next             = phase;
    length_byte_index_next = length_byte_index;
    length_low_next        = length_low;
    length_next            = length;
    payload_index_next     = payload_index;
    result.write_enable    = 1'b0;
    result.write_address   = '0;
    result.write_data      = '0;
    unique case (phase)
      PH_HUNT: begin
        if (rx_byte == cfg.sync_value) begin
          phase_next             = PH_LENGTH;
          length_byte_index_next = '0;
          length_low_next        = '0;
        end
      end
      PH_LENGTH: begin
        if (length_byte_index == 2'd3) begin
          length_byte_index_next = '0;
          if (length_full == 32'd0 || length_full > {16'd0, cfg.max_length} ||
              length_full > IndexLimit) begin
            phase_next = PH_ERROR;
          end else begin
            phase_next         = PH_PAYLOAD;
            length_next        = LENGTH_WIDTH'(length_full);
            payload_index_next = '0;
          end
        end else begin
          length_byte_index_next = length_byte_index + 2'd1;
          case (length_byte_index)
            2'd0:    length_low_next[7:0]   = rx_byte;
            2'd1:    length_low_next[15:8]  = rx_byte;
            default: length_low_next[23:16] = rx_byte;
          endcase
        end
      end
      PH_PAYLOAD: begin
        result.write_enable  = 1'b1;
        result.write_address = cfg.load_base + 32'(payload_index);
        result.write_data    = rx_byte;
        if (index_plus_one >= {1'b0, length}) begin
          phase_next = PH_DONE;
        end else begin
          payload_index_next = index_plus_one[LENGTH_WIDTH-1:0];
        end
      end
      default: ;
    endcase
    result.length_error = (phase_next == PH_ERROR);
    result.load_done    = (phase_next == PH_DONE);
  end

  // Hold frame state; advance on each taken byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HUNT;
      length_byte_index <= '0;
      length_low        <= '0;
      length            <= '0;
      payload_index     <= '0;
    end else if (take) begin
      phase             <= phase_next;
      length_byte_index <= length_byte_index_next;
      length_low        <= length_low_next;
      length            <= length_next;
      payload_index     <= payload_index_next;
    end
  end

endmodule

// ===== rtl/serial_image_loader_framer.sv =====
// ----------------------------------------------------------------------------
// serial_image_loader_framer
// Byte-stream loader framer: finds the sync byte, reads a 4-byte length and
// turns each payload byte into a memory write at load_base plus its index.
//
//   channel | direction | signals                      | content
//   --------+-----------+------------------------------+---------------------
//   s_axis  | in        | tvalid tready tdata[7:0]     | rx_byte
//   m_axis  | out       | tvalid tready tuser tdata    | one result per byte
//   cfg     | in        | valid ready index data       | register writes
//
// Every received byte gives one result. A byte is taken into an input
// register, decoded against the frame state when it moves on and lands in
// the output register, so a byte can be accepted every cycle while m_axis
// is not stalled; output valid is set as the byte lands there. Reset (rst,
// synchronous) returns to sync hunting and the register reset values. A stall
// on m_axis holds the output register and backs up into the input register.
// ----------------------------------------------------------------------------
module serial_image_loader_framer #(
  parameter int LENGTH_WIDTH = sil_pkg::LengthWidthDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input bytes
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] rx_byte
  // Results
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [sil_pkg::OutDataWidth-1:0]  m_axis_tdata,  // [31:0] write_address,
                                                            // [39:32] write_data,
                                                            // [40] length_error,
                                                            // [41] load_done
  output logic                              m_axis_tuser,  // [0] write_enable
  // Configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sil_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [sil_pkg::CfgDataWidth-1:0]  cfg_data
);
  import sil_pkg::*;

  sil_cfg_t    cfg;
  sil_result_t result;
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        take;
  sil_result_t out_result;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.load_base  <= LoadBaseReset;
      cfg.max_length <= MaxLengthReset;
      cfg.sync_value <= SyncValueReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LOAD_BASE:  cfg.load_base  <= cfg_data;
        REG_MAX_LENGTH: cfg.max_length <= cfg_data[15:0];
        REG_SYNC_VALUE: cfg.sync_value <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Move the input byte on when the output register is free or draining
  assign take          = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || take;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  sil_core #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (in_byte),
    .cfg     (cfg),
    .result  (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_result <= result;
    end
  end

  assign m_axis_tuser = out_result.write_enable;
  assign m_axis_tdata = {6'd0, out_result.load_done, out_result.length_error,
                         out_result.write_data, out_result.write_address};

endmodule

// ===== rtl/sil_checker.sv =====
// ----------------------------------------------------------------------------
// sil_checker
// Port-level checks for the serial image loader framer: sticky end states,
// exclusive flags and a held result under stall. Bound to the top level.
// ----------------------------------------------------------------------------
module sil_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [sil_pkg::OutDataWidth-1:0]  m_axis_tdata,
  input logic                              m_axis_tuser
);
  import sil_pkg::*;

  logic out_xfer;
  logic seen_done;
  logic seen_error;

  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // Track end states seen on delivered results
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_done  <= 1'b0;
      seen_error <= 1'b0;
    end else if (out_xfer) begin
      seen_done  <= seen_done || m_axis_tdata[41];
      seen_error <= seen_error || m_axis_tdata[40];
    end
  end

  // Done stays done and no more writes follow
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    out_xfer && seen_done |-> m_axis_tdata[41] && !m_axis_tuser)
    else $error("load_done dropped or write after done");

  // Error stays set and no writes follow
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    out_xfer && seen_error |-> m_axis_tdata[40] && !m_axis_tuser)
    else $error("length_error dropped or write after error");

  // Error and done never together; a write never carries an error
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[40] && (m_axis_tdata[41] || m_axis_tuser)))
    else $error("conflicting result flags");

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind serial_image_loader_framer sil_checker u_sil_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
